// ----- rtl/exptok_pkg.sv -----
// Types and constants shared by the expression tokenizer modules.
// No dependencies; compile this file first.
`default_nettype none

package exptok_pkg;

  // Fixed widths of the result word fields.
  localparam int MantOutW = 32;
  localparam int PosOutW  = 16;
  localparam int FracW    = 5;
  localparam logic [FracW-1:0] FracMax = 5'd31;

  // Output queue depth; it must hold at least the two tokens one byte can cause.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int QueueCntW  = 3;

  typedef logic [MantOutW-1:0] mant_out_t;
  typedef logic [PosOutW-1:0]  pos_out_t;

  typedef enum logic [2:0] {
    K_OP   = 3'd0,
    K_BRAC = 3'd1,
    K_NUM  = 3'd2,
    K_END  = 3'd3,
    K_ERR  = 3'd4
  } kind_t;

  localparam logic [3:0] OpAdd  = 4'd0;
  localparam logic [3:0] OpSub  = 4'd1;
  localparam logic [3:0] OpMul  = 4'd2;
  localparam logic [3:0] OpDiv  = 4'd3;
  localparam logic [3:0] OpPow  = 4'd4;
  localparam logic [3:0] OpSin  = 4'd5;
  localparam logic [3:0] OpCos  = 4'd6;
  localparam logic [3:0] OpSqrt = 4'd7;
  localparam logic [3:0] OpCbrt = 4'd8;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowC   = 8'h63;
  localparam logic [7:0] ChLowI   = 8'h69;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowO   = 8'h6F;
  localparam logic [7:0] ChLowQ   = 8'h71;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowS   = 8'h73;
  localparam logic [7:0] ChLowT   = 8'h74;

  typedef enum logic [12:0] {
    M_IDLE = 13'b0000000000001,
    M_INT  = 13'b0000000000010,
    M_FRAC = 13'b0000000000100,
    M_SKIP = 13'b0000000001000,
    M_ERR  = 13'b0000000010000,
    M_S    = 13'b0000000100000,
    M_SI   = 13'b0000001000000,
    M_SQ   = 13'b0000010000000,
    M_SQR  = 13'b0000100000000,
    M_C    = 13'b0001000000000,
    M_CO   = 13'b0010000000000,
    M_CB   = 13'b0100000000000,
    M_CBR  = 13'b1000000000000
  } mode_t;

  typedef struct packed {
    kind_t           kind;
    logic [3:0]      op;
    logic            br;
    mant_out_t       mant;
    logic [FracW-1:0] frac;
    logic            ovf;
    pos_out_t        epos;
    logic            last;
  } token_t;

  // Tokens caused by one byte: an optional leading one and an optional trailing one.
  typedef struct packed {
    logic   a_v;
    token_t a;
    logic   b_v;
    token_t b;
  } emit_t;

  function automatic token_t mk_tok(kind_t kind, logic [3:0] op, logic br,
                                    mant_out_t mant, logic [FracW-1:0] frac,
                                    logic ovf, pos_out_t epos, logic last);
    token_t t;
    t.kind = kind;
    t.op   = op;
    t.br   = br;
    t.mant = mant;
    t.frac = frac;
    t.ovf  = ovf;
    t.epos = epos;
    t.last = last;
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/exptok_in_if.sv -----
// Character input channel of the expression tokenizer.
// No dependencies.
`default_nettype none

interface exptok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// ----- rtl/exptok_out_if.sv -----
// Token output channel of the expression tokenizer.
// No dependencies.
`default_nettype none

interface exptok_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [3:0]  op_code;
  logic        bracket_right;
  logic [31:0] mantissa;
  logic [4:0]  frac_digits;
  logic        overflow;
  logic [15:0] error_position;
  logic        last;

  modport source (output valid, output token_kind, output op_code, output bracket_right,
                  output mantissa, output frac_digits, output overflow,
                  output error_position, output last, input ready);
  modport sink   (input valid, input token_kind, input op_code, input bracket_right,
                  input mantissa, input frac_digits, input overflow,
                  input error_position, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/exptok_scan.sv -----
// Lexer state and the per-byte step: number accumulation, keyword matching,
// error and terminator handling. Depends on exptok_pkg.
`default_nettype none

module exptok_scan #(
  parameter int MANTISSA_BITS = 32,
  parameter int POSITION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic [7:0]           char_code,
  output exptok_pkg::emit_t         emit
);

  localparam logic [MANTISSA_BITS-1:0] MantMax = '1;

  exptok_pkg::mode_t                 mode_r, mode_nxt;
  logic [MANTISSA_BITS-1:0]          acc_r, acc_nxt;
  logic [exptok_pkg::FracW-1:0]      frac_r, frac_nxt;
  logic                              sat_r, sat_nxt;
  logic [POSITION_BITS-1:0]          pos_r, pos_nxt;
  logic [POSITION_BITS-1:0]          kw_r, kw_nxt;

  logic                              is_term, is_digit, num_mode, fraction;
  logic [3:0]                        dval;
  logic [MANTISSA_BITS-1:0]          base_acc;
  logic [exptok_pkg::FracW-1:0]      base_frac;
  logic                              base_sat;
  logic [MANTISSA_BITS+3:0]          prod;
  logic [MANTISSA_BITS-1:0]          add_acc;
  logic [exptok_pkg::FracW-1:0]      add_frac;
  logic                              add_sat;
  logic                              kw_ok, kw_done;
  exptok_pkg::mode_t                 kw_next;
  logic [3:0]                        kw_op;

  assign is_term  = (char_code == exptok_pkg::ChNul) || (char_code == exptok_pkg::ChDollar);
  assign is_digit = (char_code >= exptok_pkg::ChZero) && (char_code <= exptok_pkg::ChNine);
  assign dval     = char_code[3:0];
  assign num_mode = (mode_r == exptok_pkg::M_INT) || (mode_r == exptok_pkg::M_FRAC);
  assign fraction = (mode_r == exptok_pkg::M_FRAC);

  // A digit either extends the number in progress or starts a new one from zero.
  assign base_acc  = num_mode ? acc_r : '0;
  assign base_frac = num_mode ? frac_r : '0;
  assign base_sat  = num_mode ? sat_r : 1'b0;

  // acc * 10 + d as (acc << 3) + (acc << 1) + d; bits above the mantissa flag overflow.
  assign prod = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1)
              + {{MANTISSA_BITS{1'b0}}, dval};

  always_comb begin
    add_acc  = base_acc;
    add_frac = base_frac;
    add_sat  = base_sat;
    if (!base_sat && !(fraction && base_frac >= exptok_pkg::FracMax)) begin
      if (|prod[MANTISSA_BITS+3:MANTISSA_BITS]) begin
        add_acc = MantMax;
        add_sat = 1'b1;
      end else begin
        add_acc  = prod[MANTISSA_BITS-1:0];
        add_frac = base_frac + {{(exptok_pkg::FracW-1){1'b0}}, fraction};
      end
    end
  end

  always_comb begin
    kw_ok   = 1'b0;
    kw_done = 1'b0;
    kw_next = exptok_pkg::M_IDLE;
    kw_op   = exptok_pkg::OpAdd;
    unique case (mode_r)
      exptok_pkg::M_S: begin
        if (char_code == exptok_pkg::ChLowI) begin
          kw_ok = 1'b1; kw_next = exptok_pkg::M_SI;
        end else if (char_code == exptok_pkg::ChLowQ) begin
          kw_ok = 1'b1; kw_next = exptok_pkg::M_SQ;
        end
      end
      exptok_pkg::M_SI: begin
        if (char_code == exptok_pkg::ChLowN) begin
          kw_ok = 1'b1; kw_done = 1'b1; kw_op = exptok_pkg::OpSin;
        end
      end
      exptok_pkg::M_SQ: begin
        if (char_code == exptok_pkg::ChLowR) begin
          kw_ok = 1'b1; kw_next = exptok_pkg::M_SQR;
        end
      end
      exptok_pkg::M_SQR: begin
        if (char_code == exptok_pkg::ChLowT) begin
          kw_ok = 1'b1; kw_done = 1'b1; kw_op = exptok_pkg::OpSqrt;
        end
      end
      exptok_pkg::M_C: begin
        if (char_code == exptok_pkg::ChLowO) begin
          kw_ok = 1'b1; kw_next = exptok_pkg::M_CO;
        end else if (char_code == exptok_pkg::ChLowB) begin
          kw_ok = 1'b1; kw_next = exptok_pkg::M_CB;
        end
      end
      exptok_pkg::M_CO: begin
        if (char_code == exptok_pkg::ChLowS) begin
          kw_ok = 1'b1; kw_done = 1'b1; kw_op = exptok_pkg::OpCos;
        end
      end
      exptok_pkg::M_CB: begin
        if (char_code == exptok_pkg::ChLowR) begin
          kw_ok = 1'b1; kw_next = exptok_pkg::M_CBR;
        end
      end
      exptok_pkg::M_CBR: begin
        if (char_code == exptok_pkg::ChLowT) begin
          kw_ok = 1'b1; kw_done = 1'b1; kw_op = exptok_pkg::OpCbrt;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    exptok_pkg::mode_t mid;
    logic              stop;
    exptok_pkg::token_t blank;

    blank    = exptok_pkg::mk_tok(exptok_pkg::K_OP, exptok_pkg::OpAdd, 1'b0, '0, '0,
                                  1'b0, '0, 1'b0);
    mid      = mode_r;
    stop     = 1'b0;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    frac_nxt = frac_r;
    sat_nxt  = sat_r;
    kw_nxt   = kw_r;
    emit.a_v = 1'b0;
    emit.a   = blank;
    emit.b_v = 1'b0;
    emit.b   = blank;

    // First pass: finish whatever token is in progress.
    unique case (mode_r)
      exptok_pkg::M_INT, exptok_pkg::M_FRAC, exptok_pkg::M_SKIP: begin
        if (is_digit) begin
          if (mode_r != exptok_pkg::M_SKIP) begin
            acc_nxt  = add_acc;
            frac_nxt = add_frac;
            sat_nxt  = add_sat;
          end
          stop = 1'b1;
        end else if (char_code == exptok_pkg::ChDot) begin
          mode_nxt = (mode_r == exptok_pkg::M_INT) ? exptok_pkg::M_FRAC : exptok_pkg::M_SKIP;
          stop     = 1'b1;
        end else begin
          emit.a_v = 1'b1;
          emit.a   = exptok_pkg::mk_tok(exptok_pkg::K_NUM, exptok_pkg::OpAdd, 1'b0,
                                        exptok_pkg::mant_out_t'(acc_r), frac_r, sat_r,
                                        '0, 1'b0);
          mid      = exptok_pkg::M_IDLE;
        end
      end
      exptok_pkg::M_IDLE, exptok_pkg::M_ERR: begin
      end
      default: begin
        if (!kw_ok) begin
          emit.a_v = 1'b1;
          emit.a   = exptok_pkg::mk_tok(exptok_pkg::K_ERR, exptok_pkg::OpAdd, 1'b0, '0, '0,
                                        1'b0, exptok_pkg::pos_out_t'(kw_r), 1'b0);
          mid      = exptok_pkg::M_ERR;
          mode_nxt = exptok_pkg::M_ERR;
          stop     = !is_term;
        end else begin
          if (kw_done) begin
            emit.a_v = 1'b1;
            emit.a   = exptok_pkg::mk_tok(exptok_pkg::K_OP, kw_op, 1'b0, '0, '0,
                                          1'b0, '0, 1'b0);
          end
          mode_nxt = kw_next;
          stop     = 1'b1;
        end
      end
    endcase

    // Second pass: terminator, error drop, or start of a new token.
    if (!stop) begin
      if (is_term) begin
        emit.b_v = 1'b1;
        emit.b   = exptok_pkg::mk_tok(exptok_pkg::K_END, exptok_pkg::OpAdd, 1'b0, '0, '0,
                                      1'b0, '0, 1'b1);
        mode_nxt = exptok_pkg::M_IDLE;
      end else if (mid == exptok_pkg::M_ERR) begin
        mode_nxt = exptok_pkg::M_ERR;
      end else begin
        mode_nxt = exptok_pkg::M_IDLE;
        priority if (char_code == exptok_pkg::ChSpace || char_code == exptok_pkg::ChTab) begin
        end else if (char_code == exptok_pkg::ChPlus || char_code == exptok_pkg::ChMinus ||
                     char_code == exptok_pkg::ChStar || char_code == exptok_pkg::ChSlash ||
                     char_code == exptok_pkg::ChCaret) begin
          emit.b_v = 1'b1;
          emit.b   = exptok_pkg::mk_tok(exptok_pkg::K_OP,
                       (char_code == exptok_pkg::ChPlus)  ? exptok_pkg::OpAdd :
                       (char_code == exptok_pkg::ChMinus) ? exptok_pkg::OpSub :
                       (char_code == exptok_pkg::ChStar)  ? exptok_pkg::OpMul :
                       (char_code == exptok_pkg::ChSlash) ? exptok_pkg::OpDiv :
                                                            exptok_pkg::OpPow,
                       1'b0, '0, '0, 1'b0, '0, 1'b0);
        end else if (char_code == exptok_pkg::ChLParen ||
                     char_code == exptok_pkg::ChRParen) begin
          emit.b_v = 1'b1;
          emit.b   = exptok_pkg::mk_tok(exptok_pkg::K_BRAC, exptok_pkg::OpAdd,
                                        char_code == exptok_pkg::ChRParen, '0, '0,
                                        1'b0, '0, 1'b0);
        end else if (char_code == exptok_pkg::ChLowS || char_code == exptok_pkg::ChLowC) begin
          mode_nxt = (char_code == exptok_pkg::ChLowS) ? exptok_pkg::M_S : exptok_pkg::M_C;
          kw_nxt   = pos_r;
        end else if (is_digit) begin
          acc_nxt  = add_acc;
          frac_nxt = add_frac;
          sat_nxt  = add_sat;
          mode_nxt = exptok_pkg::M_INT;
        end else begin
          emit.b_v = 1'b1;
          emit.b   = exptok_pkg::mk_tok(exptok_pkg::K_ERR, exptok_pkg::OpAdd, 1'b0, '0, '0,
                                        1'b0, exptok_pkg::pos_out_t'(pos_r), 1'b0);
          mode_nxt = exptok_pkg::M_ERR;
        end
      end
    end

    pos_nxt = (!stop && is_term) ? '0 : pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= exptok_pkg::M_IDLE;
      acc_r  <= '0;
      frac_r <= '0;
      sat_r  <= 1'b0;
      pos_r  <= '0;
      kw_r   <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      frac_r <= frac_nxt;
      sat_r  <= sat_nxt;
      pos_r  <= pos_nxt;
      kw_r   <= kw_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/exptok_queue.sv -----
// Token output queue: takes up to two tokens per step and presents one word per
// cycle while the output channel is ready. Depends on exptok_pkg and exptok_out_if.
`default_nettype none

module exptok_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire exptok_pkg::emit_t    emit,
  output logic                      room,
  exptok_out_if.source              out_ch
);

  exptok_pkg::token_t                     mem [exptok_pkg::QueueDepth];
  logic [exptok_pkg::QueuePtrW-1:0]       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [exptok_pkg::QueueCntW-1:0]       cnt_r, cnt_nxt;
  exptok_pkg::token_t                     t0, t1;
  logic [1:0]                             n_push;
  logic                                   pop;
  exptok_pkg::token_t                     head;

  // Pack the present tokens to the front.
  always_comb begin
    t0     = emit.a_v ? emit.a : emit.b;
    t1     = emit.b;
    n_push = push ? ({1'b0, emit.a_v} + {1'b0, emit.b_v}) : 2'd0;
  end

  assign pop  = out_ch.valid && out_ch.ready;
  assign room = (cnt_r <= exptok_pkg::QueueCntW'(exptok_pkg::QueueDepth - 2));

  assign wr_nxt  = wr_r + exptok_pkg::QueuePtrW'(n_push);
  assign rd_nxt  = rd_r + exptok_pkg::QueuePtrW'(pop);
  assign cnt_nxt = cnt_r + exptok_pkg::QueueCntW'(n_push) - exptok_pkg::QueueCntW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_r] <= t0;
    end
    if (n_push == 2'd2) begin
      mem[wr_r + 1'b1] <= t1;
    end
  end

  assign head = mem[rd_r];

  assign out_ch.valid          = (cnt_r != '0);
  assign out_ch.token_kind     = head.kind;
  assign out_ch.op_code        = head.op;
  assign out_ch.bracket_right  = head.br;
  assign out_ch.mantissa       = head.mant;
  assign out_ch.frac_digits    = head.frac;
  assign out_ch.overflow       = head.ovf;
  assign out_ch.error_position = head.epos;
  assign out_ch.last           = head.last;

endmodule

`default_nettype wire

// ----- rtl/expression_tokenizer.sv -----
// Top level of the expression tokenizer: byte input register, lexer step and
// token queue. Depends on exptok_pkg, exptok_in_if, exptok_out_if,
// exptok_scan and exptok_queue.
//
//   Channel  Direction  Word                        Handshake
//   in_ch    sink       char_code[7:0]              valid/ready
//   out_ch   source     token fields (kind .. last) valid/ready
//
// One byte is taken per cycle while the input is ready; it is latched in byte_r and
// lexed once the queue has room, and its tokens are written to a four-word queue at
// the end of that cycle, from which they are offered in order.
// A byte that yields two tokens (number then operator, error then end) leaves one
// extra word in the queue; such a byte always follows one that yields none, so
// with the output ready the input never stalls.
// Reset is synchronous and active low and clears all lexer state.
// A stalled output fills the queue; at three words lexing stops and, once a byte is held, the input deasserts ready.
`default_nettype none

module expression_tokenizer #(
  parameter int MANTISSA_BITS = 32,
  parameter int POSITION_BITS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  exptok_in_if.sink    in_ch,
  exptok_out_if.source out_ch
);

  logic              byte_v_r;
  logic [7:0]        byte_r;
  logic              room;
  logic              step;
  exptok_pkg::emit_t emit;

  assign step        = byte_v_r && room;
  assign in_ch.ready = !byte_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      byte_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.char_code;
    end
  end

  exptok_scan #(
    .MANTISSA_BITS(MANTISSA_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .char_code (byte_r),
    .emit      (emit)
  );

  exptok_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (step),
    .emit   (emit),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ----- dv/expression_tokenizer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for expression_tokenizer: directed rows, then random expressions.
// Depends on exptok_pkg, exptok_in_if, exptok_out_if and the expression_tokenizer RTL.
module expression_tokenizer_tb;

  localparam int PREDICTED = -1;
  localparam int RANDOM_CHARS = 1750;
  localparam logic [63:0] MANT_LIMIT = 64'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  exptok_in_if  in_ch ();
  exptok_out_if out_ch ();

  expression_tokenizer u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Lexer state kept by the testbench.
  exptok_pkg::mode_t lex_mode;
  logic [63:0]       digit_acc;
  logic [4:0]        frac_count;
  logic              acc_saturated;
  logic [15:0]       char_pos;
  logic [15:0]       keyword_pos;

  exptok_pkg::token_t lexed[$];
  exptok_pkg::token_t tokens_due[$];
  int                 fault_count = 0;

  // Directed rows: leading blanks, text, optional NUL, and hand-written tokens when known.
  string              row_text[$];
  bit                 row_nul[$];
  int                 row_blanks[$];
  int                 row_ntyped[$];
  exptok_pkg::token_t row_tok_a[$];
  exptok_pkg::token_t row_tok_b[$];

  logic [7:0] expr_bytes[$];
  string      keywords[4] = '{"sin", "cos", "sqrt", "cbrt"};
  logic [7:0] op_chars[5] = '{exptok_pkg::ChPlus, exptok_pkg::ChMinus, exptok_pkg::ChStar,
                              exptok_pkg::ChSlash, exptok_pkg::ChCaret};

  function automatic exptok_pkg::token_t op_tok(logic [3:0] op);
    exptok_pkg::token_t t;
    t = '0;
    t.kind = exptok_pkg::K_OP;
    t.op = op;
    return t;
  endfunction

  function automatic exptok_pkg::token_t brac_tok(logic right);
    exptok_pkg::token_t t;
    t = '0;
    t.kind = exptok_pkg::K_BRAC;
    t.br = right;
    return t;
  endfunction

  function automatic exptok_pkg::token_t num_tok(logic [31:0] mant, logic [4:0] frac,
                                                 logic ovf);
    exptok_pkg::token_t t;
    t = '0;
    t.kind = exptok_pkg::K_NUM;
    t.mant = mant;
    t.frac = frac;
    t.ovf = ovf;
    return t;
  endfunction

  function automatic exptok_pkg::token_t err_tok(logic [15:0] pos);
    exptok_pkg::token_t t;
    t = '0;
    t.kind = exptok_pkg::K_ERR;
    t.epos = pos;
    return t;
  endfunction

  function automatic exptok_pkg::token_t end_tok();
    exptok_pkg::token_t t;
    t = '0;
    t.kind = exptok_pkg::K_END;
    t.last = 1'b1;
    return t;
  endfunction

  function automatic void push_digit(logic [3:0] d, bit in_frac);
    if (acc_saturated) return;
    if (in_frac && frac_count >= exptok_pkg::FracMax) return;
    if (digit_acc > (MANT_LIMIT - 64'(d)) / 64'd10) begin
      digit_acc = MANT_LIMIT;
      acc_saturated = 1'b1;
      return;
    end
    digit_acc = digit_acc * 64'd10 + 64'(d);
    if (in_frac) frac_count = frac_count + 5'd1;
  endfunction

  // Lexes one byte and appends the tokens it causes to lexed.
  function automatic void lex_char(logic [7:0] ch);
    bit                is_term;
    bit                is_digit;
    bit                consumed;
    bit                kw_ok;
    bit                kw_done;
    exptok_pkg::mode_t nxt;
    logic [3:0]        kw_op;
    logic [15:0]       pos;
    is_term = (ch == exptok_pkg::ChNul || ch == exptok_pkg::ChDollar);
    is_digit = (ch >= exptok_pkg::ChZero && ch <= exptok_pkg::ChNine);
    pos = char_pos;
    consumed = 1'b0;
    kw_ok = 1'b1;
    kw_done = 1'b0;
    nxt = exptok_pkg::M_IDLE;
    kw_op = exptok_pkg::OpAdd;
    case (lex_mode)
      exptok_pkg::M_INT, exptok_pkg::M_FRAC, exptok_pkg::M_SKIP: begin
        if (is_digit) begin
          if (lex_mode != exptok_pkg::M_SKIP)
            push_digit(4'(ch - exptok_pkg::ChZero), lex_mode == exptok_pkg::M_FRAC);
          consumed = 1'b1;
        end else if (ch == exptok_pkg::ChDot) begin
          lex_mode = (lex_mode == exptok_pkg::M_INT) ? exptok_pkg::M_FRAC
                                                     : exptok_pkg::M_SKIP;
          consumed = 1'b1;
        end else begin
          lexed.push_back(num_tok(digit_acc[31:0], frac_count, acc_saturated));
          lex_mode = exptok_pkg::M_IDLE;
        end
      end
      exptok_pkg::M_IDLE, exptok_pkg::M_ERR: ;
      default: begin
        case (lex_mode)
          exptok_pkg::M_S: begin
            if (ch == exptok_pkg::ChLowI) nxt = exptok_pkg::M_SI;
            else if (ch == exptok_pkg::ChLowQ) nxt = exptok_pkg::M_SQ;
            else kw_ok = 1'b0;
          end
          exptok_pkg::M_SI: begin
            if (ch == exptok_pkg::ChLowN) begin kw_done = 1'b1; kw_op = exptok_pkg::OpSin; end
            else kw_ok = 1'b0;
          end
          exptok_pkg::M_SQ: begin
            if (ch == exptok_pkg::ChLowR) nxt = exptok_pkg::M_SQR;
            else kw_ok = 1'b0;
          end
          exptok_pkg::M_SQR: begin
            if (ch == exptok_pkg::ChLowT) begin kw_done = 1'b1; kw_op = exptok_pkg::OpSqrt; end
            else kw_ok = 1'b0;
          end
          exptok_pkg::M_C: begin
            if (ch == exptok_pkg::ChLowO) nxt = exptok_pkg::M_CO;
            else if (ch == exptok_pkg::ChLowB) nxt = exptok_pkg::M_CB;
            else kw_ok = 1'b0;
          end
          exptok_pkg::M_CO: begin
            if (ch == exptok_pkg::ChLowS) begin kw_done = 1'b1; kw_op = exptok_pkg::OpCos; end
            else kw_ok = 1'b0;
          end
          exptok_pkg::M_CB: begin
            if (ch == exptok_pkg::ChLowR) nxt = exptok_pkg::M_CBR;
            else kw_ok = 1'b0;
          end
          exptok_pkg::M_CBR: begin
            if (ch == exptok_pkg::ChLowT) begin kw_done = 1'b1; kw_op = exptok_pkg::OpCbrt; end
            else kw_ok = 1'b0;
          end
          default: kw_ok = 1'b0;
        endcase
        if (!kw_ok) begin
          // The byte that broke the keyword is dropped unless it ends the expression.
          lexed.push_back(err_tok(keyword_pos));
          lex_mode = exptok_pkg::M_ERR;
          if (!is_term) consumed = 1'b1;
        end else begin
          if (kw_done) lexed.push_back(op_tok(kw_op));
          lex_mode = nxt;
          consumed = 1'b1;
        end
      end
    endcase

    if (!consumed) begin
      if (is_term) begin
        lexed.push_back(end_tok());
        lex_mode = exptok_pkg::M_IDLE;
        char_pos = '0;
        return;
      end
      if (lex_mode != exptok_pkg::M_ERR) begin
        case (ch)
          exptok_pkg::ChSpace, exptok_pkg::ChTab: ;
          exptok_pkg::ChPlus:   lexed.push_back(op_tok(exptok_pkg::OpAdd));
          exptok_pkg::ChMinus:  lexed.push_back(op_tok(exptok_pkg::OpSub));
          exptok_pkg::ChStar:   lexed.push_back(op_tok(exptok_pkg::OpMul));
          exptok_pkg::ChSlash:  lexed.push_back(op_tok(exptok_pkg::OpDiv));
          exptok_pkg::ChCaret:  lexed.push_back(op_tok(exptok_pkg::OpPow));
          exptok_pkg::ChLParen: lexed.push_back(brac_tok(1'b0));
          exptok_pkg::ChRParen: lexed.push_back(brac_tok(1'b1));
          exptok_pkg::ChLowS, exptok_pkg::ChLowC: begin
            lex_mode = (ch == exptok_pkg::ChLowS) ? exptok_pkg::M_S : exptok_pkg::M_C;
            keyword_pos = pos;
          end
          default: begin
            if (is_digit) begin
              digit_acc = '0;
              frac_count = '0;
              acc_saturated = 1'b0;
              push_digit(4'(ch - exptok_pkg::ChZero), 1'b0);
              lex_mode = exptok_pkg::M_INT;
            end else begin
              lexed.push_back(err_tok(pos));
              lex_mode = exptok_pkg::M_ERR;
            end
          end
        endcase
      end
    end
    char_pos = char_pos + 16'd1;
  endfunction

  // Mostly no gap, some short ones and a few long ones.
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(5, 30));
  endfunction

  task automatic add_row(string text, bit nul, int blanks, int ntyped,
                         exptok_pkg::token_t a, exptok_pkg::token_t b);
    row_text.push_back(text);
    row_nul.push_back(nul);
    row_blanks.push_back(blanks);
    row_ntyped.push_back(ntyped);
    row_tok_a.push_back(a);
    row_tok_b.push_back(b);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) expr_bytes.push_back(s[i]);
  endtask

  task automatic push_digits(int count);
    repeat (count) expr_bytes.push_back(8'(exptok_pkg::ChZero + 8'($urandom_range(0, 9))));
  endtask

  task automatic add_number();
    int ndig;
    ndig = ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 14))
                                      : int'($urandom_range(1, 5));
    push_digits(ndig);
    if ($urandom_range(0, 2) == 0) begin
      expr_bytes.push_back(exptok_pkg::ChDot);
      ndig = ($urandom_range(0, 19) == 0) ? int'($urandom_range(28, 40))
                                         : int'($urandom_range(0, 5));
      push_digits(ndig);
      if ($urandom_range(0, 9) == 0) begin
        expr_bytes.push_back(exptok_pkg::ChDot);
        push_digits(int'($urandom_range(0, 3)));
        if ($urandom_range(0, 1) == 0) expr_bytes.push_back(exptok_pkg::ChDot);
      end
    end
  endtask

  task automatic push_blanks(int max_count);
    repeat ($urandom_range(0, max_count))
      expr_bytes.push_back(($urandom_range(0, 3) == 0) ? exptok_pkg::ChTab
                                                       : exptok_pkg::ChSpace);
  endtask

  // Mostly well-formed expressions; some carry stray bytes and cut-off keywords.
  task automatic build_expression();
    int    r;
    bit    noisy;
    string kw;
    noisy = ($urandom_range(0, 99) < 15);
    repeat ($urandom_range(1, 12)) begin
      push_blanks(2);
      r = int'($urandom_range(0, 99));
      if (noisy && r < 12) begin
        expr_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 40) begin
        add_number();
      end else if (r < 62) begin
        expr_bytes.push_back(op_chars[$urandom_range(0, 4)]);
      end else if (r < 76) begin
        expr_bytes.push_back(($urandom_range(0, 1) == 0) ? exptok_pkg::ChLParen
                                                         : exptok_pkg::ChRParen);
      end else begin
        kw = keywords[$urandom_range(0, 3)];
        if (noisy && $urandom_range(0, 2) == 0)
          kw = kw.substr(0, int'($urandom_range(0, kw.len() - 2)));
        push_text(kw);
      end
    end
    push_blanks(2);
    expr_bytes.push_back(($urandom_range(0, 9) < 7) ? exptok_pkg::ChDollar
                                                    : exptok_pkg::ChNul);
  endtask

  // Presents one byte, waits for it to be taken, then queues the tokens it should cause when predict is set.
  task automatic send_char(logic [7:0] ch, bit burst, bit predict);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_code <= ch;
    do @(posedge clk); while (!in_ch.ready);
    lexed.delete();
    lex_char(ch);
    if (predict) foreach (lexed[i]) tokens_due.push_back(lexed[i]);
  endtask

  task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fault_count++;
    end
  endtask

  task automatic check_token();
    exptok_pkg::token_t want;
    if (tokens_due.size() == 0) begin
      $error("token_kind: expected no word, got %0d", out_ch.token_kind);
      fault_count++;
      return;
    end
    want = tokens_due.pop_front();
    field_check("token_kind", 32'(want.kind), 32'(out_ch.token_kind));
    field_check("op_code", 32'(want.op), 32'(out_ch.op_code));
    field_check("bracket_right", 32'(want.br), 32'(out_ch.bracket_right));
    field_check("mantissa", want.mant, out_ch.mantissa);
    field_check("frac_digits", 32'(want.frac), 32'(out_ch.frac_digits));
    field_check("overflow", 32'(want.ovf), 32'(out_ch.overflow));
    field_check("error_position", 32'(want.epos), 32'(out_ch.error_position));
    field_check("last", 32'(want.last), 32'(out_ch.last));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_token();
  end

  // Output back-pressure: short runs with random stalls, and now and then a long clean run.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      int stall;
      out_ch.ready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8))
        @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    string zeros;
    int    sent;
    bit    burst;
    in_ch.valid = 1'b0;
    in_ch.char_code = '0;
    lex_mode = exptok_pkg::M_IDLE;
    digit_acc = '0;
    frac_count = '0;
    acc_saturated = 1'b0;
    char_pos = '0;
    keyword_pos = '0;

    zeros = "0.";
    repeat (35) zeros = {zeros, "0"};

    add_row("$", 1'b0, 0, 1, end_tok(), '0);
    add_row("+-", 1'b0, 0, 2, op_tok(exptok_pkg::OpAdd), op_tok(exptok_pkg::OpSub));
    add_row("*/", 1'b0, 0, 2, op_tok(exptok_pkg::OpMul), op_tok(exptok_pkg::OpDiv));
    add_row("^(", 1'b0, 0, 2, op_tok(exptok_pkg::OpPow), brac_tok(1'b0));
    add_row(")", 1'b1, 0, 2, brac_tok(1'b1), end_tok());
    add_row("sin cos", 1'b0, 0, PREDICTED, '0, '0);
    add_row("sqrt\tcbrt", 1'b0, 0, PREDICTED, '0, '0);
    add_row("4294967295+", 1'b0, 0, 2, num_tok(32'hFFFF_FFFF, 5'd0, 1'b0),
            op_tok(exptok_pkg::OpAdd));
    add_row("4294967296*", 1'b0, 0, 2, num_tok(32'hFFFF_FFFF, 5'd0, 1'b1),
            op_tok(exptok_pkg::OpMul));
    // Second point closes the value; trailing blank before the terminator is fine.
    add_row("0.5.7.9 $", 1'b0, 0, 2, num_tok(32'd5, 5'd1, 1'b0), end_tok());
    add_row({zeros, "$"}, 1'b0, 0, 2, num_tok(32'd0, 5'd31, 1'b0), end_tok());
    add_row(".5$", 1'b0, 0, 2, err_tok(16'd0), end_tok());
    add_row("(\200\377$", 1'b0, 0, PREDICTED, '0, '0);
    add_row("sqx$", 1'b0, 0, 2, err_tok(16'd0), end_tok());
    add_row("cb", 1'b1, 0, 2, err_tok(16'd0), end_tok());
    add_row("si $", 1'b0, 0, 2, err_tok(16'd0), end_tok());
    add_row("12 3.25 99999999999.99", 1'b1, 0, PREDICTED, '0, '0);
    add_row("7\t-2)$", 1'b0, 0, PREDICTED, '0, '0);
    // Two leading blanks put the stray byte at position 2.
    add_row("@$", 1'b0, 2, 2, err_tok(16'd2), end_tok());

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (row_text[r]) begin
      burst = (row_blanks[r] > 0) || ($urandom_range(0, 3) == 0);
      if (row_ntyped[r] > 0) tokens_due.push_back(row_tok_a[r]);
      if (row_ntyped[r] > 1) tokens_due.push_back(row_tok_b[r]);
      repeat (row_blanks[r]) send_char(exptok_pkg::ChSpace, burst, 1'b0);
      for (int j = 0; j < row_text[r].len(); j++)
        send_char(row_text[r][j], burst, row_ntyped[r] == PREDICTED);
      if (row_nul[r]) send_char(exptok_pkg::ChNul, burst, row_ntyped[r] == PREDICTED);
    end

    sent = 0;
    while (sent < RANDOM_CHARS) begin
      expr_bytes.delete();
      build_expression();
      burst = ($urandom_range(0, 3) == 0);
      foreach (expr_bytes[i]) begin
        send_char(expr_bytes[i], burst, 1'b1);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/exptok_pkg.sv
rtl/exptok_in_if.sv
rtl/exptok_out_if.sv
rtl/exptok_scan.sv
rtl/exptok_queue.sv
rtl/expression_tokenizer.sv
dv/expression_tokenizer_tb.sv
